// File: sv/rag_pkg.sv
// Shared types, codes and helpers for realtime_authority_gate.
// No dependencies; used by every module of the block.
`default_nettype none
package rag_pkg;

  localparam logic [31:0] HalfRange = 32'h8000_0000;
  localparam logic [31:0] AllOnes   = 32'hFFFF_FFFF;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] RegSession  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegContract = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLanes    = 2'd3;

  typedef enum logic [2:0] {
    KindCommand = 3'd0, KindEpochReset = 3'd1, KindArm = 3'd2, KindDisarm = 3'd3,
    KindTick = 3'd4, KindPacket = 3'd5, KindApplied = 3'd6, KindNotApplied = 3'd7
  } kind_t;

  // outcome codes (arm and packet share the field)
  localparam logic [2:0] OutOk        = 3'd0;
  localparam logic [2:0] ArmProof     = 3'd1;
  localparam logic [2:0] ArmNotReady  = 3'd2;
  localparam logic [2:0] ArmDenied    = 3'd3;
  localparam logic [2:0] ArmReplay    = 3'd4;
  localparam logic [2:0] PktPrearm    = 3'd1;
  localparam logic [2:0] PktBoot      = 3'd2;
  localparam logic [2:0] PktDup       = 3'd3;
  localparam logic [2:0] PktContract  = 3'd4;
  localparam logic [2:0] PktState     = 3'd5;
  localparam logic [2:0] PktAuthority = 3'd6;

  localparam logic [1:0] StPrearm   = 2'd0;
  localparam logic [1:0] StActive   = 2'd1;
  localparam logic [1:0] StExpired  = 2'd2;
  localparam logic [1:0] StRejected = 2'd3;

  localparam logic [3:0] RsOk       = 4'd0;
  localparam logic [3:0] RsBoot     = 4'd1;
  localparam logic [3:0] RsSequence = 4'd2;
  localparam logic [3:0] RsContract = 4'd3;
  localparam logic [3:0] RsState    = 4'd4;
  localparam logic [3:0] RsEpoch    = 4'd5;
  localparam logic [3:0] RsNotArmed = 4'd6;
  localparam logic [3:0] RsProofRef = 4'd7;
  localparam logic [3:0] RsLiveness = 4'd8;

  localparam logic [1:0] ModePrearm = 2'd1;
  localparam logic [1:0] ModeActive = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] time_ms;
    logic [63:0] packet_session;
    logic [31:0] sequence_number;
    logic [31:0] packet_contract;
    logic [31:0] lane_valid_bits;
    logic [31:0] generation;
    logic [1:0]  packet_mode;
    logic [31:0] epoch;
    logic [31:0] echoed_proof;
    logic        bus_ready;
    logic        arm_allowed;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  outcome;
    logic [1:0]  proof_status;
    logic [3:0]  proof_reason;
    logic [31:0] proof_counter;
    logic [4:0]  fresh_flags;
    logic        healthy;
    logic [31:0] forward_age;
    logic [31:0] proof_age;
    logic [31:0] timeout_count;
    logic [31:0] replay_count;
    logic [31:0] mismatch_count;
  } result_t;

  typedef struct packed {
    logic [63:0] session_id;
    logic [30:0] liveness_timeout;
    logic [31:0] contract_id;
    logic [31:0] required_lanes;
  } cfg_t;

  // cur newer than prev, wrap-safe
  function automatic logic seq_newer(input logic [31:0] prev, input logic [31:0] cur);
    logic [31:0] d;
    d = cur - prev;
    return (d != 32'd0) && (d < HalfRange);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == AllOnes) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

// File: sv/realtime_authority_gate.sv
// Top level of realtime_authority_gate: handshake, config registers, core.
// Depends on rag_pkg, rag_cfg and rag_core.
//
// Usage: events enter on the in channel (in_valid/in_ready, payload in_data),
// one result per event leaves on the out channel (out_valid/out_ready,
// payload out_data). Configuration is written through cfg_we/cfg_index/
// cfg_data while no event is in flight.
// The result of an event is registered and is on out_data in the cycle after its beat.
// Throughput: one event per cycle while the receiver keeps up; the result register frees up in the same
// cycle it is taken, so in_ready = !out_valid || out_ready.
// When the receiver stalls the result holds and in_ready drops until it is
// taken; nothing is lost. The per-event state update and report is a single
// pass of compares and 32-bit subtracts ahead of the result register.
// Reset (rst, synchronous) clears all session state, counters, the
// registers and the result valid flag.
`default_nettype none
module realtime_authority_gate (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output wire logic                          in_ready,
  input  wire rag_pkg::item_t                in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rag_pkg::result_t                   out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rag_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [rag_pkg::CfgDataW-1:0]  cfg_data
);
  rag_pkg::cfg_t cfg;
  logic fire;

  assign in_ready = !out_valid || out_ready;
  assign fire = in_valid && in_ready;

  rag_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  rag_core u_core (
    .clk(clk), .rst(rst), .fire(fire), .item(in_data), .cfg(cfg), .res(out_data)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fire) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
endmodule
`default_nettype wire

// File: sv/rag_cfg.sv
// Configuration register file for realtime_authority_gate.
// Depends on rag_pkg.
`default_nettype none
module rag_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rag_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [rag_pkg::CfgDataW-1:0]  cfg_data,
  output rag_pkg::cfg_t                      cfg
);
  // one register per index, written without wait
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rag_pkg::RegSession:  cfg.session_id       <= cfg_data;
        rag_pkg::RegTimeout:  cfg.liveness_timeout <= cfg_data[30:0];
        rag_pkg::RegContract: cfg.contract_id      <= cfg_data[31:0];
        rag_pkg::RegLanes:    cfg.required_lanes   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/rag_core.sv
// Session state and single-pass update/report logic for one event beat.
// Depends on rag_pkg.
`default_nettype none
module rag_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire rag_pkg::item_t item,
  input  wire rag_pkg::cfg_t  cfg,
  output rag_pkg::result_t    res
);
  logic armed, command_seen, activation_seen, sequence_seen;
  logic prearm_echo_valid, forward_valid, active_echo_valid, state_applied;
  logic [31:0] armed_epoch, arm_time, last_command, last_activation, highest_sequence;
  logic [31:0] issued_proof, last_echo, prearm_echo_time, forward_time, active_echo_time;
  logic [31:0] applied_generation, timeouts, replays, mismatches;
  logic [1:0] status_reg;
  logic [3:0] reason_reg;

  logic armed_next, command_seen_next, activation_seen_next, sequence_seen_next;
  logic prearm_echo_valid_next, forward_valid_next, active_echo_valid_next;
  logic state_applied_next;
  logic [31:0] armed_epoch_next, arm_time_next, last_command_next, last_activation_next;
  logic [31:0] highest_sequence_next, issued_proof_next, last_echo_next;
  logic [31:0] prearm_echo_time_next, forward_time_next, active_echo_time_next;
  logic [31:0] applied_generation_next, timeouts_next, replays_next, mismatches_next;
  logic [1:0] status_reg_next;
  logic [3:0] reason_reg_next;
  rag_pkg::result_t res_next;

  logic        configured;
  logic [31:0] tmo, now;
  logic        pre_qual_in, act_pkt, pre_pkt, ref_ok;
  logic [31:0] ref_v, inc_proof;
  logic [3:0]  iss_reason;
  logic        iss;
  logic [1:0]  iss_status;

  assign configured = (cfg.session_id != 64'd0) && (cfg.liveness_timeout != 31'd0);
  assign tmo = configured ? {1'b0, cfg.liveness_timeout} : 32'd0;
  assign now = item.time_ms;
  assign ref_v = item.echoed_proof;
  assign pre_qual_in = configured && !armed && prearm_echo_valid &&
                       ((now - prearm_echo_time) <= tmo);
  assign act_pkt = (item.packet_mode == rag_pkg::ModeActive) && armed &&
                   (item.epoch == armed_epoch);
  assign pre_pkt = (item.packet_mode == rag_pkg::ModePrearm) && (item.epoch == 32'd0) &&
                   !armed;
  assign ref_ok = !(ref_v == 32'd0 || issued_proof == 32'd0 || ref_v == last_echo ||
                    (last_echo != 32'd0 && !rag_pkg::seq_newer(last_echo, ref_v))) &&
                  (ref_v == issued_proof || rag_pkg::seq_newer(ref_v, issued_proof));
  assign inc_proof = (issued_proof + 32'd1 == 32'd0) ? 32'd1 : issued_proof + 32'd1;

  // next state for the event
  always_comb begin
    armed_next = armed; command_seen_next = command_seen;
    activation_seen_next = activation_seen; sequence_seen_next = sequence_seen;
    prearm_echo_valid_next = prearm_echo_valid; forward_valid_next = forward_valid;
    active_echo_valid_next = active_echo_valid; state_applied_next = state_applied;
    armed_epoch_next = armed_epoch; arm_time_next = arm_time;
    last_command_next = last_command; last_activation_next = last_activation;
    highest_sequence_next = highest_sequence; issued_proof_next = issued_proof;
    last_echo_next = last_echo; prearm_echo_time_next = prearm_echo_time;
    forward_time_next = forward_time; active_echo_time_next = active_echo_time;
    applied_generation_next = applied_generation; timeouts_next = timeouts;
    replays_next = replays; mismatches_next = mismatches;
    status_reg_next = status_reg; reason_reg_next = reason_reg;
    res_next = '0;
    iss = 1'b0; iss_status = rag_pkg::StPrearm; iss_reason = rag_pkg::RsOk;

    unique case (rag_pkg::kind_t'(item.kind))
      rag_pkg::KindCommand: begin
        if (!configured || item.sequence_number == 32'd0 ||
            (command_seen && !rag_pkg::seq_newer(last_command, item.sequence_number))) begin
          replays_next = rag_pkg::sat_inc(replays);
        end else begin
          command_seen_next = 1'b1;
          last_command_next = item.sequence_number;
          res_next.ok = 1'b1;
        end
      end
      rag_pkg::KindEpochReset: begin
        command_seen_next = 1'b0;
        last_command_next = 32'd0;
        if (!armed) begin
          sequence_seen_next = 1'b0; highest_sequence_next = 32'd0;
          prearm_echo_valid_next = 1'b0; prearm_echo_time_next = 32'd0;
          last_echo_next = 32'd0;
        end
      end
      rag_pkg::KindArm: begin
        if (!pre_qual_in) res_next.outcome = rag_pkg::ArmProof;
        else if (!item.bus_ready) res_next.outcome = rag_pkg::ArmNotReady;
        else if (!item.arm_allowed) res_next.outcome = rag_pkg::ArmDenied;
        else if (item.epoch == 32'd0 ||
                 (activation_seen && !rag_pkg::seq_newer(last_activation, item.epoch)))
          res_next.outcome = rag_pkg::ArmReplay;
        else begin
          res_next.ok = 1'b1;
          armed_next = 1'b1; armed_epoch_next = item.epoch;
          activation_seen_next = 1'b1; last_activation_next = item.epoch;
          arm_time_next = now; forward_valid_next = 1'b0; forward_time_next = now;
          active_echo_valid_next = 1'b0; active_echo_time_next = now;
          applied_generation_next = 32'd0; state_applied_next = 1'b0;
          status_reg_next = rag_pkg::StActive; reason_reg_next = rag_pkg::RsOk;
        end
      end
      rag_pkg::KindDisarm: begin
        armed_next = 1'b0; armed_epoch_next = 32'd0; forward_valid_next = 1'b0;
        active_echo_valid_next = 1'b0; state_applied_next = 1'b0;
        applied_generation_next = 32'd0;
        status_reg_next = rag_pkg::StPrearm; reason_reg_next = rag_pkg::RsOk;
      end
      rag_pkg::KindTick: begin
        if (armed && ((!forward_valid && (now - arm_time) > tmo) ||
                      (forward_valid && (now - forward_time) > tmo) ||
                      (active_echo_valid ? (now - active_echo_time) > tmo
                                         : (now - arm_time) > tmo))) begin
          armed_next = 1'b0; armed_epoch_next = 32'd0; forward_valid_next = 1'b0;
          active_echo_valid_next = 1'b0; state_applied_next = 1'b0;
          timeouts_next = rag_pkg::sat_inc(timeouts);
          status_reg_next = rag_pkg::StExpired; reason_reg_next = rag_pkg::RsLiveness;
          res_next.ok = 1'b1;
        end
      end
      rag_pkg::KindPacket: begin
        state_applied_next = 1'b0;
        if (!configured || item.packet_session != cfg.session_id) begin
          iss = 1'b1; iss_status = rag_pkg::StRejected; iss_reason = rag_pkg::RsBoot;
          res_next.outcome = rag_pkg::PktBoot;
        end else if (item.sequence_number == 32'd0 || (sequence_seen &&
                     !rag_pkg::seq_newer(highest_sequence, item.sequence_number))) begin
          replays_next = rag_pkg::sat_inc(replays);
          reason_reg_next = rag_pkg::RsSequence;
          res_next.outcome = rag_pkg::PktDup;
        end else begin
          sequence_seen_next = 1'b1;
          highest_sequence_next = item.sequence_number;
          iss = 1'b1;
          if (item.packet_contract != cfg.contract_id) begin
            iss_status = rag_pkg::StRejected; iss_reason = rag_pkg::RsContract;
            res_next.outcome = rag_pkg::PktContract;
          end else if ((item.lane_valid_bits & cfg.required_lanes) != cfg.required_lanes ||
                       item.generation == 32'd0) begin
            iss_status = rag_pkg::StRejected; iss_reason = rag_pkg::RsState;
            res_next.outcome = rag_pkg::PktState;
          end else if (!act_pkt && !pre_pkt) begin
            iss_status = armed ? rag_pkg::StActive : rag_pkg::StExpired;
            iss_reason = armed ? rag_pkg::RsEpoch : rag_pkg::RsNotArmed;
            res_next.outcome = rag_pkg::PktAuthority;
          end else begin
            // admitted: echo check may leave the sticky proof-ref reason
            reason_reg_next = rag_pkg::RsOk;
            if (ref_ok) begin
              if (act_pkt) begin
                active_echo_valid_next = 1'b1; active_echo_time_next = now;
              end else begin
                prearm_echo_valid_next = 1'b1; prearm_echo_time_next = now;
              end
              last_echo_next = ref_v;
            end else if (ref_v != 32'd0 && ref_v != last_echo) begin
              mismatches_next = rag_pkg::sat_inc(mismatches);
              reason_reg_next = rag_pkg::RsProofRef;
            end
            if (act_pkt) begin
              forward_valid_next = 1'b1; forward_time_next = now;
              iss_status = rag_pkg::StActive;
              res_next.outcome = rag_pkg::OutOk;
            end else begin
              iss_status = rag_pkg::StPrearm;
              res_next.outcome = rag_pkg::PktPrearm;
            end
            res_next.ok = 1'b1;
          end
        end
        if (iss) begin
          issued_proof_next = inc_proof;
          status_reg_next = iss_status;
          if (reason_reg_next != rag_pkg::RsProofRef || iss_reason != rag_pkg::RsOk)
            reason_reg_next = iss_reason;
        end
      end
      rag_pkg::KindApplied: begin
        state_applied_next = 1'b1;
        applied_generation_next = item.generation;
      end
      default: begin
        state_applied_next = 1'b0;
        reason_reg_next = rag_pkg::RsState;
      end
    endcase

    // report on the post-update state
    res_next.proof_status = status_reg_next;
    res_next.proof_reason = reason_reg_next;
    res_next.proof_counter = issued_proof_next;
    res_next.fresh_flags[0] = forward_valid_next && ((now - forward_time_next) <= tmo);
    res_next.fresh_flags[1] = armed_next ?
        (active_echo_valid_next && ((now - active_echo_time_next) <= tmo)) :
        (prearm_echo_valid_next && ((now - prearm_echo_time_next) <= tmo));
    res_next.fresh_flags[2] = configured && !armed_next && prearm_echo_valid_next &&
                              ((now - prearm_echo_time_next) <= tmo);
    res_next.fresh_flags[3] = armed_next;
    res_next.fresh_flags[4] = state_applied_next;
    res_next.healthy = configured && armed_next && forward_valid_next &&
                       active_echo_valid_next && ((now - forward_time_next) <= tmo) &&
                       ((now - active_echo_time_next) <= tmo);
    res_next.forward_age = forward_valid_next ? now - forward_time_next : rag_pkg::AllOnes;
    if (armed_next)
      res_next.proof_age = active_echo_valid_next ? now - active_echo_time_next
                                                  : rag_pkg::AllOnes;
    else
      res_next.proof_age = prearm_echo_valid_next ? now - prearm_echo_time_next
                                                  : rag_pkg::AllOnes;
    res_next.timeout_count = timeouts_next;
    res_next.replay_count = replays_next;
    res_next.mismatch_count = mismatches_next;
  end

  // state registers and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0; command_seen <= 1'b0; activation_seen <= 1'b0;
      sequence_seen <= 1'b0; prearm_echo_valid <= 1'b0; forward_valid <= 1'b0;
      active_echo_valid <= 1'b0; state_applied <= 1'b0;
      armed_epoch <= '0; arm_time <= '0; last_command <= '0; last_activation <= '0;
      highest_sequence <= '0; issued_proof <= '0; last_echo <= '0;
      prearm_echo_time <= '0; forward_time <= '0; active_echo_time <= '0;
      applied_generation <= '0; timeouts <= '0; replays <= '0; mismatches <= '0;
      status_reg <= rag_pkg::StPrearm; reason_reg <= rag_pkg::RsOk;
    end else if (fire) begin
      armed <= armed_next; command_seen <= command_seen_next;
      activation_seen <= activation_seen_next; sequence_seen <= sequence_seen_next;
      prearm_echo_valid <= prearm_echo_valid_next; forward_valid <= forward_valid_next;
      active_echo_valid <= active_echo_valid_next; state_applied <= state_applied_next;
      armed_epoch <= armed_epoch_next; arm_time <= arm_time_next;
      last_command <= last_command_next; last_activation <= last_activation_next;
      highest_sequence <= highest_sequence_next; issued_proof <= issued_proof_next;
      last_echo <= last_echo_next; prearm_echo_time <= prearm_echo_time_next;
      forward_time <= forward_time_next; active_echo_time <= active_echo_time_next;
      applied_generation <= applied_generation_next; timeouts <= timeouts_next;
      replays <= replays_next; mismatches <= mismatches_next;
      status_reg <= status_reg_next; reason_reg <= reason_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res <= res_next;
  end
endmodule
`default_nettype wire

// File: sv/rag_checker.sv
// Port-level checker for realtime_authority_gate, bound to the top level.
// Depends on rag_pkg.
`default_nettype none
module rag_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire rag_pkg::result_t out_data
);
  // an accepted beat always yields a result next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid) else $error("result missing");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result lost");
  // the replay counter never moves backwards between results
  a_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) && !$past(rst) |->
      out_data.replay_count >= $past(out_data.replay_count))
    else $error("replay count fell");
  // healthy implies the active flag and the forward-fresh flag set
  a_health: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.healthy |-> out_data.fresh_flags[3] && out_data.fresh_flags[0])
    else $error("healthy without active");
endmodule

bind realtime_authority_gate rag_checker u_rag_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// File: tb/rag_checker.sv
// Checker for realtime_authority_gate: watches the event, result and register
// write ports, predicts each result and compares field by field. Uses rag_pkg.
module rag_scoreboard (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  rag_pkg::item_t   in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  rag_pkg::result_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  output int               fail_count,
  output int               pending
);
  import rag_pkg::*;

  // register copy
  logic [63:0] m_session;
  logic [30:0] m_timeout;
  logic [31:0] m_contract, m_lanes;

  // session state copy
  logic        s_armed, s_cmd_seen, s_act_seen, s_seq_seen;
  logic [31:0] s_arm_epoch, s_arm_time, s_last_cmd, s_last_act, s_high_seq;
  logic [31:0] s_proof, s_last_echo, s_pre_time, s_fwd_time, s_act_echo_time, s_app_gen;
  logic        s_pre_valid, s_fwd_valid, s_act_echo_valid, s_applied;
  logic [31:0] s_timeouts, s_replays, s_mismatches;
  logic [1:0]  s_status;
  logic [3:0]  s_reason;

  result_t expected_results[$];

  function automatic logic configured();
    return m_session != 64'd0 && m_timeout != 31'd0;
  endfunction

  function automatic logic [31:0] limit_ms();
    return configured() ? {1'b0, m_timeout} : 32'd0;
  endfunction

  function automatic logic newer(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return d != 0 && d < 32'h8000_0000;
  endfunction

  function automatic logic fresh(input logic [31:0] now, input logic [31:0] t0);
    return (now - t0) <= limit_ms();
  endfunction

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function automatic logic prearm_ok(input logic [31:0] now);
    return configured() && !s_armed && s_pre_valid && fresh(now, s_pre_time);
  endfunction

  function automatic void issue_proof(input logic [1:0] st, input logic [3:0] rs);
    s_proof = s_proof + 1;
    if (s_proof == 0) s_proof = 1;
    s_status = st;
    if (s_reason != RsProofRef || rs != RsOk) s_reason = rs;
  endfunction

  function automatic void drop_session();
    s_armed = 0; s_arm_epoch = 0; s_fwd_valid = 0; s_act_echo_valid = 0; s_applied = 0;
  endfunction

  function automatic void take_echo(input logic [31:0] r, input logic [31:0] now,
                                    input logic on_act);
    logic good;
    good = !(r == 0 || s_proof == 0 || r == s_last_echo ||
             (s_last_echo != 0 && !newer(s_last_echo, r)))
           && (r == s_proof || newer(r, s_proof));
    if (!good) begin
      if (r != 0 && r != s_last_echo) begin
        s_mismatches = bump(s_mismatches);
        s_reason = RsProofRef;
      end
    end else begin
      if (on_act) begin
        s_act_echo_valid = 1; s_act_echo_time = now;
      end else begin
        s_pre_valid = 1; s_pre_time = now;
      end
      s_last_echo = r;
    end
  endfunction

  function automatic logic [2:0] packet_step(input item_t it);
    logic act, pre;
    s_applied = 0;
    if (!configured() || it.packet_session != m_session) begin
      issue_proof(StRejected, RsBoot);
      return PktBoot;
    end
    if (it.sequence_number == 0 || (s_seq_seen && !newer(s_high_seq, it.sequence_number)))
    begin
      s_replays = bump(s_replays);
      s_reason = RsSequence;
      return PktDup;
    end
    s_seq_seen = 1;
    s_high_seq = it.sequence_number;
    if (it.packet_contract != m_contract) begin
      issue_proof(StRejected, RsContract);
      return PktContract;
    end
    if ((it.lane_valid_bits & m_lanes) != m_lanes || it.generation == 0) begin
      issue_proof(StRejected, RsState);
      return PktState;
    end
    act = it.packet_mode == ModeActive && s_armed && it.epoch == s_arm_epoch;
    pre = it.packet_mode == ModePrearm && it.epoch == 0 && !s_armed;
    if (!act && !pre) begin
      if (s_armed) issue_proof(StActive, RsEpoch);
      else issue_proof(StExpired, RsNotArmed);
      return PktAuthority;
    end
    s_reason = RsOk;
    take_echo(it.echoed_proof, it.time_ms, act);
    if (act) begin
      s_fwd_valid = 1; s_fwd_time = it.time_ms;
      issue_proof(StActive, RsOk);
      return OutOk;
    end
    issue_proof(StPrearm, RsOk);
    return PktPrearm;
  endfunction

  function automatic result_t gate_predict(input item_t it);
    result_t r;
    logic [31:0] now, lim;
    logic ret_fresh;
    now = it.time_ms;
    r = '0;
    case (kind_t'(it.kind))
      KindCommand: begin
        if (!configured() || it.sequence_number == 0 ||
            (s_cmd_seen && !newer(s_last_cmd, it.sequence_number)))
          s_replays = bump(s_replays);
        else begin
          s_cmd_seen = 1; s_last_cmd = it.sequence_number; r.ok = 1;
        end
      end
      KindEpochReset: begin
        s_cmd_seen = 0; s_last_cmd = 0;
        if (!s_armed) begin
          s_seq_seen = 0; s_high_seq = 0; s_pre_valid = 0; s_pre_time = 0; s_last_echo = 0;
        end
      end
      KindArm: begin
        if (!configured() || !prearm_ok(now)) r.outcome = ArmProof;
        else if (!it.bus_ready) r.outcome = ArmNotReady;
        else if (!it.arm_allowed || s_armed) r.outcome = ArmDenied;
        else if (it.epoch == 0 || (s_act_seen && !newer(s_last_act, it.epoch)))
          r.outcome = ArmReplay;
        else begin
          r.outcome = OutOk;
          s_armed = 1; s_arm_epoch = it.epoch; s_act_seen = 1; s_last_act = it.epoch;
          s_arm_time = now; s_fwd_valid = 0; s_fwd_time = now;
          s_act_echo_valid = 0; s_act_echo_time = now; s_app_gen = 0; s_applied = 0;
          s_status = StActive; s_reason = RsOk;
        end
        r.ok = r.outcome == OutOk;
      end
      KindDisarm: begin
        drop_session();
        s_app_gen = 0; s_status = StPrearm; s_reason = RsOk;
      end
      KindTick: begin
        lim = limit_ms();
        if (s_armed && ((!s_fwd_valid && (now - s_arm_time) > lim) ||
            (s_fwd_valid && (now - s_fwd_time) > lim) ||
            (s_act_echo_valid ? (now - s_act_echo_time) > lim : (now - s_arm_time) > lim)))
        begin
          drop_session();
          s_timeouts = bump(s_timeouts);
          s_status = StExpired; s_reason = RsLiveness;
          r.ok = 1;
        end
      end
      KindPacket: begin
        r.outcome = packet_step(it);
        r.ok = r.outcome <= PktPrearm;
      end
      KindApplied: begin
        s_applied = 1; s_app_gen = it.generation;
      end
      default: begin
        s_applied = 0; s_reason = RsState;
      end
    endcase
    ret_fresh = s_armed ? (s_act_echo_valid && fresh(now, s_act_echo_time))
                        : (s_pre_valid && fresh(now, s_pre_time));
    r.fresh_flags = {s_applied, s_armed, prearm_ok(now), ret_fresh,
                     s_fwd_valid && fresh(now, s_fwd_time)};
    r.healthy = configured() && s_armed && s_fwd_valid && s_act_echo_valid &&
                fresh(now, s_fwd_time) && fresh(now, s_act_echo_time);
    r.forward_age = s_fwd_valid ? now - s_fwd_time : 32'hFFFF_FFFF;
    if (s_armed) r.proof_age = s_act_echo_valid ? now - s_act_echo_time : 32'hFFFF_FFFF;
    else r.proof_age = s_pre_valid ? now - s_pre_time : 32'hFFFF_FFFF;
    r.proof_status = s_status;
    r.proof_reason = s_reason;
    r.proof_counter = s_proof;
    r.timeout_count = s_timeouts;
    r.replay_count = s_replays;
    r.mismatch_count = s_mismatches;
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // compare one result beat against the oldest expectation
  task automatic compare_beat(input result_t g);
    result_t e;
    if (expected_results.size() == 0) begin
      $display("[%0t] unexpected result beat", $realtime);
      fail_count++;
    end else begin
      e = expected_results.pop_front();
      if (g.ok !== e.ok) report("ok", g.ok, e.ok);
      if (g.outcome !== e.outcome) report("outcome", g.outcome, e.outcome);
      if (g.proof_status !== e.proof_status) report("proof_status", g.proof_status, e.proof_status);
      if (g.proof_reason !== e.proof_reason) report("proof_reason", g.proof_reason, e.proof_reason);
      if (g.proof_counter !== e.proof_counter)
        report("proof_counter", g.proof_counter, e.proof_counter);
      if (g.fresh_flags !== e.fresh_flags) report("fresh_flags", g.fresh_flags, e.fresh_flags);
      if (g.healthy !== e.healthy) report("healthy", g.healthy, e.healthy);
      if (g.forward_age !== e.forward_age) report("forward_age", g.forward_age, e.forward_age);
      if (g.proof_age !== e.proof_age) report("proof_age", g.proof_age, e.proof_age);
      if (g.timeout_count !== e.timeout_count)
        report("timeout_count", g.timeout_count, e.timeout_count);
      if (g.replay_count !== e.replay_count) report("replay_count", g.replay_count, e.replay_count);
      if (g.mismatch_count !== e.mismatch_count)
        report("mismatch_count", g.mismatch_count, e.mismatch_count);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_session = 0; m_timeout = 0; m_contract = 0; m_lanes = 0;
      s_armed = 0; s_cmd_seen = 0; s_act_seen = 0; s_seq_seen = 0;
      s_arm_epoch = 0; s_arm_time = 0; s_last_cmd = 0; s_last_act = 0; s_high_seq = 0;
      s_proof = 0; s_last_echo = 0; s_pre_time = 0; s_fwd_time = 0; s_act_echo_time = 0;
      s_app_gen = 0; s_pre_valid = 0; s_fwd_valid = 0; s_act_echo_valid = 0; s_applied = 0;
      s_timeouts = 0; s_replays = 0; s_mismatches = 0; s_status = StPrearm; s_reason = RsOk;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) compare_beat(out_data);
      if (cfg_we) begin
        case (cfg_index)
          RegSession:  m_session = cfg_data;
          RegTimeout:  m_timeout = cfg_data[30:0];
          RegContract: m_contract = cfg_data[31:0];
          default:     m_lanes = cfg_data[31:0];
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(gate_predict(in_data));
    end
    pending = expected_results.size();
  end
endmodule

// File: tb/tb_top.sv
// Top of the realtime_authority_gate testbench: clock, reset, register
// writes and event stimulus. Depends on rag_pkg, the block and rag_scoreboard.
module tb_top;
  import rag_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  item_t       in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  result_t     out_data;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [63:0] cfg_data = 0;
  int          fail_count, pending;
  int          idle_pct = 19;

  // session state as the stimulus sees it, to build well-formed traffic
  logic [31:0] now_ms, seq_ctr, cmd_ctr, epoch_ctr, proof_guess;
  logic [63:0] cur_session;
  logic [30:0] cur_timeout;
  logic [31:0] cur_contract, cur_lanes;

  always #6 clk = ~clk;

  realtime_authority_gate u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rag_scoreboard u_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stalls at random
  always @(negedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  // keep proof reference near the issued counter seen on results
  always @(posedge clk) if (out_valid && out_ready) proof_guess <= out_data.proof_counter;

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // caller is at a falling edge; the sender goes idle here
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic configure(input logic [63:0] ses, input logic [30:0] tmo,
                           input logic [31:0] con, input logic [31:0] lanes);
    drain();
    cur_session = ses; cur_timeout = tmo; cur_contract = con; cur_lanes = lanes;
    write_reg(RegSession, ses);
    write_reg(RegTimeout, {33'd0, tmo});
    write_reg(RegContract, {32'd0, con});
    write_reg(RegLanes, {32'd0, lanes});
  endtask

  // send one event beat; caller is at a falling edge, valid stays up after
  // the beat until the next idle cycle or drain
  task automatic send(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic item_t noise_item();
    item_t it;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  // a mostly well-formed event with random content
  function automatic item_t shaped_item();
    item_t it;
    int sel;
    it = noise_item();
    it.packet_mode = ($urandom_range(9) < 8) ? ($urandom_range(1) ? ModeActive : ModePrearm)
                                             : it.packet_mode;
    now_ms = now_ms + $urandom_range(cur_timeout > 40 ? 40 : 3);
    if ($urandom_range(49) == 0) now_ms = now_ms + $urandom;
    it.time_ms = now_ms;
    sel = $urandom_range(99);
    if (sel < 45) it.kind = KindPacket;
    else if (sel < 55) it.kind = KindArm;
    else if (sel < 65) it.kind = KindTick;
    else if (sel < 75) it.kind = KindCommand;
    else if (sel < 80) it.kind = KindApplied;
    else if (sel < 83) it.kind = KindNotApplied;
    else if (sel < 87) it.kind = KindDisarm;
    else if (sel < 90) it.kind = KindEpochReset;
    else it.kind = kind_t'($urandom_range(7));
    if ($urandom_range(9) < 8) begin
      it.packet_session = cur_session;
      it.packet_contract = cur_contract;
      it.lane_valid_bits = it.lane_valid_bits | cur_lanes;
      if (it.generation == 0) it.generation = 1;
      seq_ctr = seq_ctr + $urandom_range(1, 3);
      it.sequence_number = ($urandom_range(15) == 0) ? seq_ctr - 2 : seq_ctr;
      if (it.kind == KindCommand) begin
        cmd_ctr = cmd_ctr + $urandom_range(1, 2);
        it.sequence_number = ($urandom_range(9) == 0) ? cmd_ctr - 1 : cmd_ctr;
      end
      it.echoed_proof = proof_guess + $urandom_range(0, 3);
      if ($urandom_range(7) == 0) it.echoed_proof = 0;
      it.bus_ready = $urandom_range(9) != 0;
      it.arm_allowed = $urandom_range(9) != 0;
      if (it.kind == KindArm) begin
        epoch_ctr = epoch_ctr + $urandom_range(1, 2);
        it.epoch = ($urandom_range(9) == 0) ? epoch_ctr - 1 : epoch_ctr;
      end else if (it.packet_mode == ModePrearm) it.epoch = 0;
      else it.epoch = epoch_ctr;
    end
    return it;
  endfunction

  initial begin
    item_t it;
    now_ms = 0; seq_ctr = 0; cmd_ctr = 0; epoch_ctr = 0; proof_guess = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // unconfigured: every kind once; command replay, arm needs proof, packet boot mismatch, tick
    for (int k = 0; k < 8; k++) begin
      it = '0;
      it.kind = kind_t'(k);
      it.sequence_number = 5;
      it.time_ms = k;
      send(it);
    end

    // directed arm sequence with extreme registers
    configure(64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    it = '0; it.kind = KindPacket; it.packet_session = '1; it.packet_contract = '1;
    it.lane_valid_bits = '1; it.generation = '1; it.packet_mode = ModePrearm;
    it.sequence_number = 1; it.time_ms = 100;
    send(it);
    it.sequence_number = 2; it.echoed_proof = 1; it.time_ms = 101;
    send(it);
    it.sequence_number = 2;  // duplicate
    send(it);
    it = '0; it.kind = KindArm; it.epoch = 7; it.bus_ready = 1; it.arm_allowed = 1;
    it.time_ms = 102;
    send(it);
    send(it);                // already armed
    it = '0; it.kind = KindPacket; it.packet_session = '1; it.packet_contract = '1;
    it.lane_valid_bits = '1; it.generation = 3; it.packet_mode = ModeActive; it.epoch = 7;
    it.sequence_number = 32'hFFFF_FFFF; it.echoed_proof = 3; it.time_ms = 103;
    send(it);
    it.packet_mode = 2'd3; it.sequence_number = 32'h7FFF_FFFF;  // other mode
    send(it);
    it = '0; it.kind = KindEpochReset; send(it);
    it.kind = KindTick; it.time_ms = 32'hFFFF_FFFF; send(it);
    it.kind = KindDisarm; send(it);

    // random phases across several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(64'd1, 31'd1, 32'd0, 32'd0);
        1: configure({$urandom, $urandom}, 31'd50, $urandom, $urandom & 32'h0000_0F0F);
        2: configure(64'd0, 31'd50, 32'd5, 32'd0);
        3: configure(64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: configure({$urandom, $urandom}, 31'd20, $urandom, 32'd0);
        default: configure(64'd9, 31'd0, 32'd0, 32'd1);
      endcase
      idle_pct = (ph == 3) ? 0 : 19;
      for (int n = 0; n < 230; n++) begin
        send(($urandom_range(9) == 0) ? noise_item() : shaped_item());
        if (n == 100) drain();
      end
    end

    drain();
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
